/* rtl/core/rsls_pkg.sv */
package rsls_pkg;

   // Sizing
   localparam int MAX_DELIM   = 16;
   localparam int COUNT_BITS  = 16;
   localparam int STORE_DEPTH = MAX_DELIM + 1;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
   localparam int CH_W        = 21;
   localparam int OUT_LEN_W   = 16;
   localparam int SAT_W       = (COUNT_BITS > OUT_LEN_W) ? COUNT_BITS : OUT_LEN_W;

   // Character codes
   localparam logic [CH_W-1:0] CH_R         = CH_W'(8'h52);
   localparam logic [CH_W-1:0] CH_QUOTE     = CH_W'(8'h22);
   localparam logic [CH_W-1:0] CH_LPAREN    = CH_W'(8'h28);
   localparam logic [CH_W-1:0] CH_RPAREN    = CH_W'(8'h29);
   localparam logic [CH_W-1:0] CH_SPACE     = CH_W'(8'h20);
   localparam logic [CH_W-1:0] CH_BACKSLASH = CH_W'(8'h5C);
   localparam logic [CH_W-1:0] CH_TAB       = CH_W'(8'h09);
   localparam logic [CH_W-1:0] CH_VTAB      = CH_W'(8'h0B);
   localparam logic [CH_W-1:0] CH_FFEED     = CH_W'(8'h0C);
   localparam logic [CH_W-1:0] CH_NEWLINE   = CH_W'(8'h0A);

   typedef enum logic [2:0] {
      PH_EXPECT_R,
      PH_EXPECT_QUOTE,
      PH_DELIM,
      PH_BODY,
      PH_MATCH
   } phase_type;

   typedef enum logic [1:0] {
      ST_SCAN,
      ST_ACCEPT,
      ST_BAD,
      ST_END
   } status_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            text_end;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [OUT_LEN_W-1:0] length;
   } rsp_type;

   typedef struct packed {
      phase_type             phase;
      logic [LEN_W-1:0]      dlen;
      logic [LEN_W-1:0]      match_idx;
      logic [COUNT_BITS-1:0] count;
   } scan_state_type;

   typedef struct packed {
      logic            en;
      logic [IDX_W-1:0] idx;
      logic [CH_W-1:0]  data;
   } store_wr_type;

endpackage

/* rtl/core/rsls_delim_store.sv */
module rsls_delim_store (
   input  logic                        clock,
   input  rsls_pkg::store_wr_type      wr,
   input  logic [rsls_pkg::IDX_W-1:0]  rd_idx,
   output logic [rsls_pkg::CH_W-1:0]   rd_data
);
   import rsls_pkg::*;

   // Delimiter characters followed by the closing quote
   logic [CH_W-1:0] store_ff [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.idx] <= wr.data;
      end
   end

   assign rd_data = store_ff[rd_idx];

endmodule

/* rtl/core/rsls_step.sv */
module rsls_step (
   input  rsls_pkg::req_type          beat,
   input  rsls_pkg::scan_state_type   cur,
   input  logic [rsls_pkg::CH_W-1:0]  want_raw,
   output rsls_pkg::scan_state_type   nxt,
   output rsls_pkg::store_wr_type     wr,
   output rsls_pkg::rsp_type          res
);
   import rsls_pkg::*;

   logic                  forbidden;
   logic [COUNT_BITS-1:0] count_inc;
   logic [CH_W-1:0]       want;
   logic [LEN_W-1:0]      match_next;
   logic [SAT_W-1:0]      cnt_ext;
   scan_state_type        upd;
   status_type            status;

   assign forbidden = (beat.ch == CH_SPACE) || (beat.ch == CH_RPAREN) ||
                      (beat.ch == CH_BACKSLASH) || (beat.ch == CH_TAB) ||
                      (beat.ch == CH_VTAB) || (beat.ch == CH_FFEED) ||
                      (beat.ch == CH_NEWLINE);

   // Saturating count
   assign count_inc  = (cur.count == '1) ? cur.count : cur.count + 1'b1;
   assign want       = (cur.match_idx < LEN_W'(STORE_DEPTH)) ? want_raw : '0;
   assign match_next = cur.match_idx + 1'b1;

   // One step of the scanner
   always_comb begin
      upd     = cur;
      status  = ST_SCAN;
      wr.en   = 1'b0;
      wr.idx  = cur.dlen[IDX_W-1:0];
      wr.data = beat.ch;
      if (beat.text_end) begin
         status = ST_END;
      end else begin
         case (cur.phase)
            PH_EXPECT_R: begin
               if (beat.ch == CH_R) begin
                  upd.phase = PH_EXPECT_QUOTE;
                  upd.count = count_inc;
               end else begin
                  status = ST_BAD;
               end
            end
            PH_EXPECT_QUOTE: begin
               if (beat.ch == CH_QUOTE) begin
                  upd.phase = PH_DELIM;
                  upd.count = count_inc;
               end else begin
                  status = ST_BAD;
               end
            end
            PH_DELIM: begin
               if (forbidden) begin
                  status = ST_BAD;
               end else if (beat.ch == CH_LPAREN) begin
                  wr.en     = (cur.dlen < LEN_W'(STORE_DEPTH));
                  wr.data   = CH_QUOTE;
                  upd.dlen  = cur.dlen + 1'b1;
                  upd.phase = PH_BODY;
                  upd.count = count_inc;
               end else if (cur.dlen >= LEN_W'(MAX_DELIM)) begin
                  status = ST_BAD;
               end else begin
                  wr.en     = 1'b1;
                  upd.dlen  = cur.dlen + 1'b1;
                  upd.count = count_inc;
               end
            end
            PH_BODY: begin
               if (beat.ch == CH_RPAREN) begin
                  upd.match_idx = '0;
                  upd.phase     = PH_MATCH;
               end
               upd.count = count_inc;
            end
            PH_MATCH: begin
               upd.count = count_inc;
               if (beat.ch == want) begin
                  upd.match_idx = match_next;
                  if (match_next >= cur.dlen) begin
                     status = ST_ACCEPT;
                  end
               end else if (beat.ch == CH_RPAREN) begin
                  upd.match_idx = '0;
               end else begin
                  upd.phase = PH_BODY;
               end
            end
            default: begin
               upd.phase = PH_EXPECT_R;
            end
         endcase
      end
   end

   // Length field, saturated to its width
   assign cnt_ext    = SAT_W'(upd.count);
   assign res.status = status;
   assign res.length = (cnt_ext > SAT_W'({OUT_LEN_W{1'b1}})) ? {OUT_LEN_W{1'b1}}
                                                            : cnt_ext[OUT_LEN_W-1:0];

   // Any terminal status returns to idle
   always_comb begin
      nxt = upd;
      if (status != ST_SCAN) begin
         nxt.phase     = PH_EXPECT_R;
         nxt.dlen      = '0;
         nxt.match_idx = '0;
         nxt.count     = '0;
      end
   end

endmodule

/* rtl/core/raw_string_literal_scanner.sv */
// Raw string literal scanner: takes one code point per beat (or an end-of-text
// mark) and follows a C++ raw string literal R"delim(body)delim", giving one
// result beat per input beat with a status (scanning, accepted on the closing
// quote, malformed, or text ended unterminated) and the saturating count of
// characters consumed so far. Delimiters longer than 16 characters are
// malformed. A new beat is taken every cycle unless the output stalls; each
// result is registered, the path being input register, one step of scan
// logic with a single delimiter-store read, then the result register.
module raw_string_literal_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsls_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsls_pkg::rsp_type rsp_data
);
   import rsls_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff;
   scan_state_type  state_ff, state_in;
   store_wr_type    wr;
   store_wr_type    wr_gated;
   rsp_type         step_res;
   logic [CH_W-1:0] want_raw;
   logic            out_free;
   logic            fire;

   // Handshake
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   // Store writes only on a step that is taken
   assign wr_gated.en   = wr.en && fire;
   assign wr_gated.idx  = wr.idx;
   assign wr_gated.data = wr.data;

   rsls_delim_store u_store (
      .clock   (clock),
      .wr      (wr_gated),
      .rd_idx  (state_ff.match_idx[IDX_W-1:0]),
      .rd_data (want_raw)
   );

   rsls_step u_step (
      .beat     (in_data_ff),
      .cur      (state_ff),
      .want_raw (want_raw),
      .nxt      (state_in),
      .wr       (wr),
      .res      (step_res)
   );

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_EXPECT_R, dlen: '0, match_idx: '0, count: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_EXPECT_R |-> state_ff.count == '0 && state_ff.dlen == '0)
      else $error("idle phase with leftover count or delimiter");

   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_MATCH |-> state_ff.match_idx < state_ff.dlen)
      else $error("match index beyond stored delimiter");

   a_terminal_idle: assert property (@(posedge clock) disable iff (reset)
      fire && step_res.status != ST_SCAN |=> state_ff.phase == PH_EXPECT_R)
      else $error("terminal status did not return to idle");

   a_dlen_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.dlen <= LEN_W'(STORE_DEPTH))
      else $error("delimiter length overflow");

endmodule
